/* rtl/udcd_pkg.sv */
package udcd_pkg;

  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_TILDE = 8'h7E;
  localparam logic [7:0] ASCII_UC_A  = 8'h41;
  localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_G      = 8'h67;
  localparam logic [7:0] CHAR_B      = 8'h62;

  localparam logic [2:0] REPLY_OK   = 3'd0;
  localparam logic [2:0] REPLY_GO   = 3'd1;
  localparam logic [2:0] REPLY_BACK = 3'd2;
  localparam logic [2:0] REPLY_RUN  = 3'd3;
  localparam logic [2:0] REPLY_IDLE = 3'd4;

  localparam logic [7:0] CFG_LEFT_SPEED  = 8'd0;
  localparam logic [7:0] CFG_RIGHT_SPEED = 8'd1;

  localparam logic [9:0] DUTY_CLAMP     = 10'd999;
  localparam logic [9:0] LEFT_SPEED_RST  = 10'd355;
  localparam logic [9:0] RIGHT_SPEED_RST = 10'd345;

  // "status" is six characters; index of its last one
  localparam logic [2:0] STATUS_LAST = 3'd5;

  // queue between front and back; depth is a power of two
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic       eol;
    logic [7:0] ch;
  } udcd_item_t;

  typedef struct packed {
    logic       valid;
    udcd_item_t item;
  } udcd_queue_t;

  typedef struct packed {
    logic [2:0] reply_code;
    logic       motors_set;
    logic [9:0] left_duty;
    logic [9:0] right_duty;
    logic       wheels_forward;
  } udcd_result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_EMIT
  } udcd_back_state_t;

  function automatic logic [7:0] status_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h73;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h75;
      3'd5:    c = 8'h73;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [9:0] clamp_duty(input logic [9:0] v);
    return (v > DUTY_CLAMP) ? DUTY_CLAMP : v;
  endfunction

endpackage

/* rtl/udcd_front.sv */
module udcd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] byte_in
  output udcd_pkg::udcd_queue_t q,
  input  logic               q_pop
);

  localparam int PW = $clog2(udcd_pkg::QDEPTH);
  localparam int CW = $clog2(udcd_pkg::QDEPTH + 1);

  udcd_pkg::udcd_item_t slots [udcd_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic is_eol;
  logic is_print;
  logic push;
  logic pop;
  udcd_pkg::udcd_item_t item_in;

  assign is_eol   = (s_tdata == udcd_pkg::ASCII_LF) || (s_tdata == udcd_pkg::ASCII_CR);
  assign is_print = (s_tdata >= udcd_pkg::ASCII_SPACE) && (s_tdata <= udcd_pkg::ASCII_TILDE);
  assign s_tready = (count != CW'(udcd_pkg::QDEPTH));

  // drop control bytes at the door; only characters and line ends go on
  assign push = s_tvalid && s_tready && (is_eol || is_print);
  assign pop  = q_pop && (count != '0);

  always_comb begin
    item_in.eol = is_eol;
    // fold upper case here so the back compares plain bytes
    if ((s_tdata >= udcd_pkg::ASCII_UC_A) && (s_tdata <= udcd_pkg::ASCII_UC_Z)) begin
      item_in.ch = s_tdata + 8'd32;
    end else begin
      item_in.ch = s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign q.valid = (count != '0);
  assign q.item  = slots[rd_ptr];

endmodule

/* rtl/udcd_back.sv */
module udcd_back #(
  parameter int LINE_MAX = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  udcd_pkg::udcd_queue_t  q,
  output logic                   q_pop,
  input  logic [9:0]             left_speed,
  input  logic [9:0]             right_speed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output udcd_pkg::udcd_result_t out_res
);

  localparam int AW = $clog2(LINE_MAX);
  localparam logic [AW-1:0] LEN_LIMIT = AW'(LINE_MAX - 1);

  logic [7:0] line_mem [LINE_MAX];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic mem_we;

  udcd_pkg::udcd_back_state_t state, state_next;
  logic [AW-1:0] len, len_next;
  logic [AW-1:0] s_idx, s_next;
  logic [AW-1:0] e_idx, e_next;
  logic seen, seen_next;
  logic running, running_next;
  logic [AW-1:0] base, base_next;
  logic [2:0] idx, idx_next;
  logic is_status, is_status_next;
  logic mismatch, mismatch_next;
  udcd_pkg::udcd_result_t res_pend, res_next;
  logic out_valid_next;
  udcd_pkg::udcd_result_t out_res_next;

  logic [AW-1:0] trim_len;
  logic one_len;
  logic six_len;
  logic mm;

  assign trim_len = e_idx - s_idx;
  assign one_len  = seen && (trim_len == AW'(1));
  assign six_len  = seen && (trim_len == AW'(6));
  assign rd_addr  = base + AW'(idx);
  assign mm       = mismatch || (rd_data != udcd_pkg::status_char(idx));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[len] <= q.item.ch;
    end
    rd_data <= line_mem[rd_addr];
  end

  always_comb begin
    state_next     = state;
    len_next       = len;
    s_next         = s_idx;
    e_next         = e_idx;
    seen_next      = seen;
    running_next   = running;
    base_next      = base;
    idx_next       = idx;
    is_status_next = is_status;
    mismatch_next  = mismatch;
    res_next       = res_pend;
    out_valid_next = out_valid && !out_ready;
    out_res_next   = out_res;
    mem_we         = 1'b0;
    q_pop          = 1'b0;
    unique case (state)
      udcd_pkg::BK_IDLE: begin
        if (q.valid) begin
          q_pop = 1'b1;
          if (!q.item.eol) begin
            if (len < LEN_LIMIT) begin
              mem_we   = 1'b1;
              len_next = len + AW'(1);
              // track the span from first to last non-space as the line grows
              if (q.item.ch != udcd_pkg::ASCII_SPACE) begin
                if (!seen) begin
                  s_next    = len;
                  seen_next = 1'b1;
                end
                e_next = len + AW'(1);
              end
            end else begin
              len_next  = '0;
              seen_next = 1'b0;
            end
          end else if (len != '0) begin
            len_next       = '0;
            seen_next      = 1'b0;
            base_next      = s_idx;
            idx_next       = '0;
            mismatch_next  = 1'b0;
            is_status_next = six_len;
            if (one_len || six_len) begin
              state_next = udcd_pkg::BK_READ;
            end
          end
        end
      end
      udcd_pkg::BK_READ: begin
        state_next = udcd_pkg::BK_CHECK;
      end
      udcd_pkg::BK_CHECK: begin
        state_next = udcd_pkg::BK_IDLE;
        if (!is_status) begin
          res_next = '0;
          if (rd_data == udcd_pkg::CHAR_T) begin
            running_next        = 1'b0;
            res_next.reply_code = udcd_pkg::REPLY_OK;
            res_next.motors_set = 1'b1;
            state_next          = udcd_pkg::BK_EMIT;
          end else if ((rd_data == udcd_pkg::CHAR_G) || (rd_data == udcd_pkg::CHAR_B)) begin
            running_next            = 1'b1;
            res_next.reply_code     = (rd_data == udcd_pkg::CHAR_G) ?
                                      udcd_pkg::REPLY_GO : udcd_pkg::REPLY_BACK;
            res_next.motors_set     = 1'b1;
            res_next.left_duty      = udcd_pkg::clamp_duty(left_speed);
            res_next.right_duty     = udcd_pkg::clamp_duty(right_speed);
            res_next.wheels_forward = (rd_data == udcd_pkg::CHAR_G);
            state_next              = udcd_pkg::BK_EMIT;
          end
        end else if (idx == udcd_pkg::STATUS_LAST) begin
          if (!mm) begin
            res_next            = '0;
            res_next.reply_code = running ? udcd_pkg::REPLY_RUN : udcd_pkg::REPLY_IDLE;
            state_next          = udcd_pkg::BK_EMIT;
          end
        end else begin
          mismatch_next = mm;
          idx_next      = idx + 3'd1;
          state_next    = udcd_pkg::BK_READ;
        end
      end
      udcd_pkg::BK_EMIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_res_next   = res_pend;
          state_next     = udcd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = udcd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= udcd_pkg::BK_IDLE;
      len       <= '0;
      s_idx     <= '0;
      e_idx     <= '0;
      seen      <= 1'b0;
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      s_idx     <= s_next;
      e_idx     <= e_next;
      seen      <= seen_next;
      running   <= running_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    base      <= base_next;
    idx       <= idx_next;
    is_status <= is_status_next;
    mismatch  <= mismatch_next;
    res_pend  <= res_next;
    out_res   <= out_res_next;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    seen |-> ((s_idx < e_idx) && (e_idx <= len)))
    else $error("trim span outside the line");

  assert property (@(posedge clk) disable iff (rst)
    (state != udcd_pkg::BK_IDLE) |-> !q_pop)
    else $error("queue popped while a line end is in progress");

  assert property (@(posedge clk) disable iff (rst)
    (state == udcd_pkg::BK_EMIT && out_valid && !out_ready) |=>
      (state == udcd_pkg::BK_EMIT))
    else $error("pending result left while output register busy");

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (len < LEN_LIMIT))
    else $error("line store written past its limit");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.reply_code == udcd_pkg::REPLY_GO ||
                   out_res.reply_code == udcd_pkg::REPLY_BACK)) |-> out_res.motors_set)
    else $error("drive reply without motor update");
`endif

endmodule

/* rtl/uart_drive_command_decoder.sv */
// Byte beats enter a 4-entry queue at up to one per cycle while it has room; the back end
// takes one queued item per cycle for a character or an empty or unmatched line end.
// A line end that trims to one or six characters leaves the queue; the back end then
// reads the line store one byte at a time, through a read and a check state per byte,
// and holds any result in the emit state until m_tready frees the output register.
// Synchronous reset empties the queue and the line, clears the run flag and
// loads speeds 355 and 345; the line store is not cleared.
module uart_drive_command_decoder #(
  parameter int LINE_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] reply_code, [3] motors_set, [13:4] left_duty,
                                 // [23:14] right_duty, [24] wheels_forward
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  udcd_pkg::udcd_queue_t  q;
  logic                   q_pop;
  udcd_pkg::udcd_result_t res;
  logic [9:0]             left_speed;
  logic [9:0]             right_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed  <= udcd_pkg::LEFT_SPEED_RST;
      right_speed <= udcd_pkg::RIGHT_SPEED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        udcd_pkg::CFG_LEFT_SPEED:  left_speed  <= cfg_data[9:0];
        udcd_pkg::CFG_RIGHT_SPEED: right_speed <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  udcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q        (q),
    .q_pop    (q_pop)
  );

  udcd_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q           (q),
    .q_pop       (q_pop),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res)
  );

  assign m_tdata = {7'd0, res.wheels_forward, res.right_duty, res.left_duty,
                    res.motors_set, res.reply_code};

endmodule

/* bench/tb_uart_drive_command_decoder.sv */
module tb_uart_drive_command_decoder;
  import udcd_pkg::*;

  localparam int LINE_CAP      = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 260;
  // first register index past the end of the register list
  localparam logic [7:0] CFG_UNUSED = 8'd2;

  class drive_scoreboard;
    logic [7:0]   line_buf [LINE_CAP];
    int unsigned  line_len;
    bit           running;
    logic [9:0]   left_spd;
    logic [9:0]   right_spd;
    udcd_result_t pending_replies[$];
    int           errors;

    function new();
      line_len  = 0;
      running   = 1'b0;
      left_spd  = LEFT_SPEED_RST;
      right_spd = RIGHT_SPEED_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
      if (idx == CFG_LEFT_SPEED) begin
        left_spd = data[9:0];
      end else if (idx == CFG_RIGHT_SPEED) begin
        right_spd = data[9:0];
      end
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      return (c >= ASCII_UC_A && c <= ASCII_UC_Z) ? c + 8'd32 : c;
    endfunction

    function logic [9:0] limit_duty(logic [9:0] v);
      return (v > DUTY_CLAMP) ? DUTY_CLAMP : v;
    endfunction

    // update the line and queue the reply that a byte beat causes, if any
    function void note_byte(logic [7:0] c);
      int unsigned  first;
      int unsigned  stop;
      int unsigned  n;
      logic [7:0]   cmd;
      string        word;
      bit           hit;
      udcd_result_t r;
      word = "status";
      if (c != ASCII_LF && c != ASCII_CR) begin
        if (c < ASCII_SPACE || c > ASCII_TILDE) return;
        if (line_len < LINE_CAP - 1) begin
          line_buf[line_len] = c;
          line_len++;
        end else begin
          line_len = 0;
        end
        return;
      end
      if (line_len == 0) return;
      first = 0;
      while (first < line_len && line_buf[first] == ASCII_SPACE) first++;
      stop = line_len;
      while (stop > first && line_buf[stop - 1] == ASCII_SPACE) stop--;
      n = stop - first;
      line_len = 0;
      r = '0;
      if (n == 1) begin
        cmd = lower(line_buf[first]);
        if (cmd == CHAR_T) begin
          running = 1'b0;
          r.reply_code = REPLY_OK;
          r.motors_set = 1'b1;
          pending_replies.push_back(r);
        end else if (cmd == CHAR_G || cmd == CHAR_B) begin
          running = 1'b1;
          r.reply_code     = (cmd == CHAR_G) ? REPLY_GO : REPLY_BACK;
          r.motors_set     = 1'b1;
          r.left_duty      = limit_duty(left_spd);
          r.right_duty     = limit_duty(right_spd);
          r.wheels_forward = (cmd == CHAR_G);
          pending_replies.push_back(r);
        end
      end else if (n == word.len()) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (lower(line_buf[first + i]) != word[i]) hit = 1'b0;
        end
        if (hit) begin
          r.reply_code = running ? REPLY_RUN : REPLY_IDLE;
          pending_replies.push_back(r);
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_reply(logic [31:0] d);
      udcd_result_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: reply beat %h with nothing expected, expected none, actual %h",
                 $time, d, d);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("reply_code", 32'(want.reply_code), 32'(d[2:0]));
      compare_field("motors_set", 32'(want.motors_set), 32'(d[3]));
      compare_field("left_duty", 32'(want.left_duty), 32'(d[13:4]));
      compare_field("right_duty", 32'(want.right_duty), 32'(d[23:14]));
      compare_field("wheels_forward", 32'(want.wheels_forward), 32'(d[24]));
      compare_field("tdata padding", 0, 32'(d[31:25]));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  drive_scoreboard sb = new();
  logic [7:0]      line_q[$];
  int              sent_bytes = 0;
  int              quiet_cycles = 0;
  bit              calm = 1'b0;
  bit              hold_req = 1'b0;
  bit              hold_active = 1'b0;

  uart_drive_command_decoder #(
    .LINE_MAX(LINE_CAP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_reply(m_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_uart_drive_command_decoder: done, errors");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] junk_byte();
    logic [7:0] c;
    c = ASCII_LF;
    while (c == ASCII_LF || c == ASCII_CR || (c >= ASCII_SPACE && c <= ASCII_TILDE)) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // leave tvalid high after the beat so the next byte can follow back to back
  task automatic send_byte(logic [7:0] b, bit gaps);
    int gap;
    gap = (gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
  endtask

  task automatic flush_line(bit gaps);
    foreach (line_q[i]) send_byte(line_q[i], gaps);
    line_q.delete();
  endtask

  task automatic queue_text(string t, logic [7:0] term);
    for (int i = 0; i < t.len(); i++) line_q.push_back(t[i]);
    line_q.push_back(term);
  endtask

  task automatic queue_random_line();
    int         kind;
    int         len;
    string      word;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      case ($urandom_range(0, 3))
        0:       word = "t";
        1:       word = "g";
        2:       word = "b";
        default: word = "status";
      endcase
      repeat ($urandom_range(0, 2)) line_q.push_back(ASCII_SPACE);
      for (int i = 0; i < word.len(); i++) begin
        c = word[i];
        if ($urandom_range(0, 1)) c = c - 8'd32;
        if ($urandom_range(0, 7) == 0) line_q.push_back(junk_byte());
        line_q.push_back(c);
      end
      repeat ($urandom_range(0, 2)) line_q.push_back(ASCII_SPACE);
    end else if (kind < 67) begin
      case ($urandom_range(0, 4))
        0:       word = "stat";
        1:       word = "statuss";
        2:       word = "st atus";
        3:       word = "tg";
        default: word = "statu5";
      endcase
      for (int i = 0; i < word.len(); i++) line_q.push_back(word[i]);
    end else if (kind < 76) begin
      len = $urandom_range(1, 8);
      repeat (len) line_q.push_back(8'($urandom_range(ASCII_SPACE, ASCII_TILDE)));
    end else if (kind < 87) begin
      len = $urandom_range(1, 10);
      repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 93) begin
      repeat ($urandom_range(0, 3)) line_q.push_back(ASCII_SPACE);
    end else begin
      // often long enough to run past a full line
      len = $urandom_range(60, 70);
      repeat (len) line_q.push_back(8'($urandom_range(ASCII_SPACE, ASCII_TILDE)));
      if ($urandom_range(0, 1)) line_q.push_back(CHAR_G);
    end
    line_q.push_back($urandom_range(0, 1) ? ASCII_CR : ASCII_LF);
    if ($urandom_range(0, 5) == 0) line_q.push_back(ASCII_LF);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait out every expected reply, then let lines that reply nothing finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int goal;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_text("status", ASCII_CR);
    queue_text("t", ASCII_LF);
    line_q.push_back(8'h00);
    line_q.push_back(ASCII_SPACE);
    line_q.push_back(8'h47);
    line_q.push_back(8'hFF);
    queue_text(" ", ASCII_CR);
    line_q.push_back(ASCII_CR);
    queue_text("~b", ASCII_LF);
    queue_text("StAtUs", ASCII_LF);
    queue_text("B", ASCII_CR);
    flush_line(1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          cfg_write(CFG_LEFT_SPEED, 16'd0);
          cfg_write(CFG_RIGHT_SPEED, 16'd1023);
          cfg_write(CFG_UNUSED, 16'hFFFF);
        end
        1: begin
          cfg_write(CFG_RIGHT_SPEED, 16'd0);
          cfg_write(CFG_LEFT_SPEED, 16'd1023);
        end
        2: begin
          cfg_write(CFG_LEFT_SPEED, 16'hFC00 | 16'd999);
          cfg_write(CFG_RIGHT_SPEED, 16'd1000);
        end
        3: begin
          cfg_write(CFG_LEFT_SPEED, 16'($urandom_range(0, 65535)));
          cfg_write(CFG_RIGHT_SPEED, 16'($urandom_range(0, 65535)));
          cfg_write(8'($urandom_range(CFG_UNUSED, 255)), 16'($urandom_range(0, 65535)));
        end
        default: begin
          cfg_write(CFG_LEFT_SPEED, 16'($urandom_range(0, 1023)));
          cfg_write(CFG_RIGHT_SPEED, 16'($urandom_range(0, 1023)));
        end
      endcase
      cfg_valid <= 1'b0;
      if (ph == 1) begin
        // back-to-back commands against a stalled receiver fill the block
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk);
        repeat (24) begin
          queue_text("g", ASCII_CR);
          flush_line(1'b0);
        end
      end
      if (ph == 4) calm = 1'b1;
      goal = sent_bytes + PHASE_BYTES;
      while (sent_bytes < goal) begin
        queue_random_line();
        flush_line(!calm && $urandom_range(0, 1));
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("tb_uart_drive_command_decoder: done, clean");
    end else begin
      $display("tb_uart_drive_command_decoder: done, errors");
    end
    $finish;
  end

endmodule
